// File: design/analog_stick_radial_deadzone_core_assert.svh
// assertion macros for the radial deadzone core checker
// no dependencies
`ifndef ANALOG_STICK_RADIAL_DEADZONE_CORE_ASSERT_SVH
`define ANALOG_STICK_RADIAL_DEADZONE_CORE_ASSERT_SVH

// same-cycle implication
`define ASRD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("asrd check failed");

// next-cycle implication
`define ASRD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("asrd check failed");

`endif

// File: design/asrd_pkg.sv
// types, widths and register codes for the radial deadzone core
// no dependencies
`timescale 1ns / 1ps
package asrd_pkg;

  localparam int unsigned FRAC_BITS = 15;
  localparam int unsigned ONE_INT   = 1 << FRAC_BITS;
  localparam int unsigned ONE_W     = FRAC_BITS + 1;

  localparam int unsigned AXIS_W    = 16;
  localparam int unsigned DZ_W      = 15;
  localparam int unsigned M2_W      = 32;
  localparam int unsigned SQ_REM_W  = 33;
  localparam int unsigned ROOT_W    = 16;
  localparam int unsigned MPOS_W    = 15;
  localparam int unsigned MSCL_W    = 16;
  localparam int unsigned NUM0_W    = ROOT_W + MPOS_W;
  localparam int unsigned NUM_W     = NUM0_W + MSCL_W;
  localparam int unsigned DEN0_W    = ROOT_W + ONE_W;
  localparam int unsigned DEN_W     = DEN0_W + FRAC_BITS;
  localparam int unsigned N_W       = NUM_W + AXIS_W;
  localparam int unsigned Q_W       = 16;
  localparam int unsigned REM_W     = ((N_W > DEN_W + Q_W) ? N_W : DEN_W + Q_W) + 1;
  localparam int unsigned LO_W      = 24;
  localparam int unsigned HI_W      = NUM_W - LO_W;

  typedef enum logic [1:0] {
    REG_DEAD_ZONE = 2'd0,
    REG_MOD_SCALE = 2'd1,
    REG_DETECT    = 2'd2,
    REG_MAX_POS   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [AXIS_W-1:0] ax;
    logic [AXIS_W-1:0] ay;
    logic              neg_x;
    logic              neg_y;
    logic              pressed;
    logic              skip;
  } side_t;

  typedef struct packed {
    logic [SQ_REM_W-1:0] rem;
    logic [ROOT_W-1:0]   root;
    side_t               side;
  } sqrt_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [Q_W-1:0]   quo;
    logic             neg;
    logic             sat;
    logic             skip;
  } lane_t;

endpackage

// File: design/asrd_sqrt_cell.sv
// one bit of the square root chain
// depends on asrd_pkg
`timescale 1ns / 1ps
module asrd_sqrt_cell import asrd_pkg::*; #(
  parameter int unsigned BIT = 0
) (
  input  logic  clk_i,
  input  logic  en_i,
  input  sqrt_t cell_i,
  output sqrt_t cell_o
);

  logic [SQ_REM_W-1:0] trial;
  sqrt_t cell_d, cell_q;

  always_comb begin
    trial  = (SQ_REM_W'(cell_i.root) << (BIT + 1)) + (SQ_REM_W'(1) << (2 * BIT));
    cell_d = cell_i;
    if (cell_i.rem >= trial) begin
      cell_d.rem  = cell_i.rem - trial;
      cell_d.root = cell_i.root | (ROOT_W'(1) << BIT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// File: design/asrd_div_cell.sv
// one quotient bit of the restoring division chain
// depends on asrd_pkg
`timescale 1ns / 1ps
module asrd_div_cell import asrd_pkg::*; #(
  parameter int unsigned BIT = 0
) (
  input  logic  clk_i,
  input  logic  en_i,
  input  lane_t cell_i,
  output lane_t cell_o
);

  logic [REM_W-1:0] trial;
  lane_t cell_d, cell_q;

  always_comb begin
    trial  = REM_W'(cell_i.den) << BIT;
    cell_d = cell_i;
    if (cell_i.rem >= trial) begin
      cell_d.rem = cell_i.rem - trial;
      cell_d.quo = cell_i.quo | (Q_W'(1) << BIT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

// File: design/analog_stick_radial_deadzone_core.sv
// top level of the radial deadzone core: config registers, pipeline and cell chains
// depends on asrd_pkg, asrd_sqrt_cell and asrd_div_cell
`timescale 1ns / 1ps
// Takes one stick sample per clock while ready and returns its pad position.
// The magnitude comes from a chain of 16 square root cells, one root bit each, and
// each axis is divided in a chain of 16 restoring division cells, one quotient bit
// each; multiplies sit in their own registered stages between them. Every stage
// moves on when the one after it is empty or moving, so stick_ready_o drops only
// when all 40 stages hold samples and the output is not taken. Config registers
// are written at any time with cfg_ready_o always high, but should change only
// while the pipeline is empty.
module analog_stick_radial_deadzone_core import asrd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               stick_valid_i,
  output logic               stick_ready_o,
  input  logic signed [15:0] stick_x_i,
  input  logic signed [15:0] stick_y_i,
  input  logic [14:0]        modifier_strength_i,
  output logic               pad_valid_o,
  input  logic               pad_ready_i,
  output logic signed [15:0] pad_x_o,
  output logic signed [15:0] pad_y_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  localparam int unsigned ST_SQ0 = 2;
  localparam int unsigned ST_A   = ST_SQ0 + ROOT_W;
  localparam int unsigned ST_B   = ST_A + 1;
  localparam int unsigned ST_C   = ST_B + 1;
  localparam int unsigned ST_D   = ST_C + 1;
  localparam int unsigned ST_E   = ST_D + 1;
  localparam int unsigned ST_DV0 = ST_E + 1;
  localparam int unsigned ST_OUT = ST_DV0 + Q_W;
  localparam int unsigned NST    = ST_OUT + 1;

  // config registers
  logic [DZ_W-1:0]   dead_zone_q;
  logic [MSCL_W-1:0] mod_scale_q;
  logic [DZ_W-1:0]   detect_q;
  logic [MPOS_W-1:0] max_pos_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dead_zone_q <= '0;
      mod_scale_q <= MSCL_W'(32768);
      detect_q    <= DZ_W'(16384);
      max_pos_q   <= MPOS_W'(156);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_DEAD_ZONE: dead_zone_q <= cfg_data_i[DZ_W-1:0];
        REG_MOD_SCALE: mod_scale_q <= cfg_data_i[MSCL_W-1:0];
        REG_DETECT:    detect_q    <= cfg_data_i[DZ_W-1:0];
        REG_MAX_POS:   max_pos_q   <= cfg_data_i[MPOS_W-1:0];
        default:       ;
      endcase
    end
  end

  logic [DZ_W-1:0]  dz_eff;
  logic [ONE_W-1:0] one_minus_dz;

  assign dz_eff       = (32'(dead_zone_q) >= ONE_INT) ? DZ_W'(ONE_INT - 1) : dead_zone_q;
  assign one_minus_dz = ONE_W'(ONE_INT) - ONE_W'(dz_eff);

  // stage valids and enables
  logic [NST-1:0] vld_q;
  logic [NST-1:0] en;
  logic [NST-1:0] vld_in;

  assign en[NST-1] = !vld_q[NST-1] || pad_ready_i;
  for (genvar k = 0; k < NST - 1; k++) begin : g_en
    assign en[k] = !vld_q[k] || en[k+1];
  end
  assign vld_in        = {vld_q[NST-2:0], stick_valid_i};
  assign stick_ready_o = en[0];
  assign pad_valid_o   = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_in[k];
        end
      end
    end
  end

  // stage 0: magnitudes and signs
  side_t s0_d, s0_q;

  always_comb begin
    s0_d.ax      = stick_x_i[15] ? AXIS_W'(-stick_x_i) : AXIS_W'(stick_x_i);
    s0_d.ay      = stick_y_i[15] ? AXIS_W'(-stick_y_i) : AXIS_W'(stick_y_i);
    s0_d.neg_x   = stick_x_i[15];
    s0_d.neg_y   = !stick_y_i[15] && (stick_y_i != '0);
    s0_d.pressed = modifier_strength_i > detect_q;
    s0_d.skip    = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s0_q <= s0_d;
    end
  end

  // stage 1: squared magnitude
  logic [M2_W-1:0]   m2_q;
  logic [2*DZ_W-1:0] dz2_q;
  side_t             s1_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      m2_q  <= M2_W'(M2_W'(s0_q.ax) * M2_W'(s0_q.ax)) + M2_W'(M2_W'(s0_q.ay) * M2_W'(s0_q.ay));
      dz2_q <= (2*DZ_W)'(dz_eff) * (2*DZ_W)'(dz_eff);
      s1_q  <= s0_q;
    end
  end

  // square root chain
  sqrt_t sq_in;
  sqrt_t sq_q [ROOT_W];

  always_comb begin
    sq_in.rem       = SQ_REM_W'(m2_q);
    sq_in.root      = '0;
    sq_in.side      = s1_q;
    sq_in.side.skip = (m2_q < M2_W'(dz2_q)) || (m2_q == '0);
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    asrd_sqrt_cell #(
      .BIT(ROOT_W - 1 - k)
    ) u_cell (
      .clk_i  (clk_i),
      .en_i   (en[ST_SQ0+k]),
      .cell_i ((k == 0) ? sq_in : sq_q[(k == 0) ? 0 : k-1]),
      .cell_o (sq_q[k])
    );
  end

  // stage a: numerator and denominator base terms
  logic [NUM0_W-1:0] num0_q;
  logic [DEN0_W-1:0] den0_q;
  side_t             sa_q;
  logic [ROOT_W-1:0] mag;

  assign mag = sq_q[ROOT_W-1].root;

  always_ff @(posedge clk_i) begin
    if (en[ST_A]) begin
      num0_q <= NUM0_W'(mag - ROOT_W'(dz_eff)) * NUM0_W'(max_pos_q);
      den0_q <= DEN0_W'(mag) * DEN0_W'(one_minus_dz);
      sa_q   <= sq_q[ROOT_W-1].side;
    end
  end

  // stage b: modifier scale
  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] den_b_q;
  side_t            sb_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_B]) begin
      num_q   <= sa_q.pressed ? NUM_W'(num0_q) * NUM_W'(mod_scale_q) : NUM_W'(num0_q);
      den_b_q <= sa_q.pressed ? DEN_W'(den0_q) << FRAC_BITS : DEN_W'(den0_q);
      sb_q    <= sa_q;
    end
  end

  // stage c: partial products of axis times numerator
  logic [AXIS_W+LO_W-1:0] px_lo_q, py_lo_q;
  logic [AXIS_W+HI_W-1:0] px_hi_q, py_hi_q;
  logic [DEN_W-1:0]       den_c_q;
  side_t                  sc_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_C]) begin
      px_lo_q <= (AXIS_W+LO_W)'(sb_q.ax) * (AXIS_W+LO_W)'(num_q[LO_W-1:0]);
      py_lo_q <= (AXIS_W+LO_W)'(sb_q.ay) * (AXIS_W+LO_W)'(num_q[LO_W-1:0]);
      px_hi_q <= (AXIS_W+HI_W)'(sb_q.ax) * (AXIS_W+HI_W)'(num_q[NUM_W-1:LO_W]);
      py_hi_q <= (AXIS_W+HI_W)'(sb_q.ay) * (AXIS_W+HI_W)'(num_q[NUM_W-1:LO_W]);
      den_c_q <= den_b_q;
      sc_q    <= sb_q;
    end
  end

  // stage d: dividends
  logic [N_W-1:0]   nx_q, ny_q;
  logic [DEN_W-1:0] den_d_q;
  side_t            sd_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_D]) begin
      nx_q    <= N_W'(px_lo_q) + (N_W'(px_hi_q) << LO_W);
      ny_q    <= N_W'(py_lo_q) + (N_W'(py_hi_q) << LO_W);
      den_d_q <= den_c_q;
      sd_q    <= sc_q;
    end
  end

  // stage e: overflow check and division setup
  lane_t lx_d, ly_d, lx_q, ly_q;
  logic [REM_W-1:0] den_lim;

  always_comb begin
    den_lim   = REM_W'(den_d_q) << Q_W;
    lx_d.rem  = REM_W'(nx_q);
    lx_d.den  = den_d_q;
    lx_d.quo  = '0;
    lx_d.neg  = sd_q.neg_x;
    lx_d.sat  = REM_W'(nx_q) >= den_lim;
    lx_d.skip = sd_q.skip;
    ly_d.rem  = REM_W'(ny_q);
    ly_d.den  = den_d_q;
    ly_d.quo  = '0;
    ly_d.neg  = sd_q.neg_y;
    ly_d.sat  = REM_W'(ny_q) >= den_lim;
    ly_d.skip = sd_q.skip;
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_E]) begin
      lx_q <= lx_d;
      ly_q <= ly_d;
    end
  end

  // division chains
  lane_t dx_q [Q_W];
  lane_t dy_q [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_div
    asrd_div_cell #(
      .BIT(Q_W - 1 - k)
    ) u_cell_x (
      .clk_i  (clk_i),
      .en_i   (en[ST_DV0+k]),
      .cell_i ((k == 0) ? lx_q : dx_q[(k == 0) ? 0 : k-1]),
      .cell_o (dx_q[k])
    );
    asrd_div_cell #(
      .BIT(Q_W - 1 - k)
    ) u_cell_y (
      .clk_i  (clk_i),
      .en_i   (en[ST_DV0+k]),
      .cell_i ((k == 0) ? ly_q : dy_q[(k == 0) ? 0 : k-1]),
      .cell_o (dy_q[k])
    );
  end

  // output register with sign and saturation
  logic [15:0] pad_x_d, pad_y_d, pad_x_q, pad_y_q;
  lane_t       fx, fy;

  assign fx = dx_q[Q_W-1];
  assign fy = dy_q[Q_W-1];

  always_comb begin
    if (fx.skip) begin
      pad_x_d = '0;
    end else if (fx.neg) begin
      pad_x_d = (fx.sat || fx.quo[15]) ? 16'h8000 : 16'(-fx.quo);
    end else begin
      pad_x_d = (fx.sat || fx.quo >= 16'h7fff) ? 16'h7fff : fx.quo;
    end
    if (fy.skip) begin
      pad_y_d = '0;
    end else if (fy.neg) begin
      pad_y_d = (fy.sat || fy.quo[15]) ? 16'h8000 : 16'(-fy.quo);
    end else begin
      pad_y_d = (fy.sat || fy.quo >= 16'h7fff) ? 16'h7fff : fy.quo;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_OUT]) begin
      pad_x_q <= pad_x_d;
      pad_y_q <= pad_y_d;
    end
  end

  assign pad_x_o = pad_x_q;
  assign pad_y_o = pad_y_q;

endmodule

// File: design/asrd_checker.sv
// port-level checks for the radial deadzone core, bound to the top level
// depends on analog_stick_radial_deadzone_core_assert.svh
`timescale 1ns / 1ps
`include "analog_stick_radial_deadzone_core_assert.svh"
module asrd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        stick_ready_o,
  input logic        pad_valid_o,
  input logic        pad_ready_i,
  input logic [15:0] pad_x_o,
  input logic [15:0] pad_y_o,
  input logic        cfg_ready_o
);

  `ASRD_ASSERT_IMP(a_cfg_always_ready, clk_i, rst_ni, 1'b1, cfg_ready_o)
  `ASRD_ASSERT_IMP(a_backpressure_only_when_stalled, clk_i, rst_ni, !stick_ready_o, pad_valid_o && !pad_ready_i)
  `ASRD_ASSERT_IMP(a_no_result_after_reset, clk_i, rst_ni, $rose(rst_ni), !pad_valid_o)
  `ASRD_ASSERT_NXT(a_result_held, clk_i, rst_ni, pad_valid_o && !pad_ready_i, pad_valid_o && $stable(pad_x_o) && $stable(pad_y_o))

endmodule

bind analog_stick_radial_deadzone_core asrd_checker u_asrd_checker (.*);
